// ----- design/sta_pkg.sv -----
// Package with the constants and codes of the session table with aging.
`timescale 1ns / 1ps
`default_nettype none
package sta_pkg;
	localparam int NumBuckets     = 16;
	localparam int SlotsPerBucket = 16;
	localparam int NumCursors     = 8;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_FIND   = 3'd1,
		CMD_UPDATE = 3'd2,
		CMD_AGE    = 3'd3,
		CMD_COPEN  = 3'd4,
		CMD_CNEXT  = 3'd5,
		CMD_CVALID = 3'd6,
		CMD_NONE   = 3'd7
	} cmd_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
endpackage
`default_nettype wire

// ----- design/session_table_with_aging_core.sv -----
// Top level of the session table with aging: command sequencer around the slot memories.
//
// Channel  Direction  Payload
// s_axis   in         tdata: cmd, bucket_num, sess_id, timestamp, cutoff, cursor_num (131 of 136 bits)
// m_axis   out        tdata: status, hit_bucket, hit_slot, sess_id_out, last_seen_out,
//                     removed_total, cursor_ok (84 of 88 bits)
//
// One word is worked on at a time. Insert, cursor open, cursor valid and unused codes are
// settled in the dispatch state; cursor next reads the slot under its cursor when one is left.
// Find and update read and compare each slot in turn and step past each bucket they leave, so
// a miss walks every slot of the table. Age out steps past an empty bucket; on a filled one it
// reads each slot, writes back the slots it keeps and then settles the bucket's fill and epoch.
// A finished result is staged and moved into the output register once that is free, so the
// next word is taken while a result waits; a stalled receiver then holds the sequencer in its
// final state and the input stays closed.
// Reset clears the bucket and cursor tables at once; the slot memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module session_table_with_aging_core #(
	parameter int NUM_BUCKETS      = sta_pkg::NumBuckets,
	parameter int SLOTS_PER_BUCKET = sta_pkg::SlotsPerBucket,
	parameter int NUM_CURSORS      = sta_pkg::NumCursors
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// cmd[2:0], bucket_num[18:3], sess_id[50:19], timestamp[82:51], cutoff[114:83],
	// cursor_num[130:115], zero fill above
	input  wire logic [135:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status[1:0], hit_bucket[5:2], hit_slot[9:6], sess_id_out[41:10],
	// last_seen_out[73:42], removed_total[82:74], cursor_ok[83], zero fill above
	output logic [87:0]       m_axis_tdata
);
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int CW = (NUM_CURSORS > 1) ? $clog2(NUM_CURSORS) : 1;
	localparam int AW = BW + SW;
	localparam int NW = $clog2(NUM_BUCKETS * SLOTS_PER_BUCKET + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_AGE_BKT, S_AGE_RD, S_AGE_WR,
		S_AGE_END, S_NEXT_RD, S_NEXT_OUT, S_UPD_OUT, S_DONE
	} state_t;

	// Slot memories, packed bucket by bucket.
	logic [31:0] mem_sess [NUM_BUCKETS*SLOTS_PER_BUCKET];
	logic [31:0] mem_time [NUM_BUCKETS*SLOTS_PER_BUCKET];

	logic [NUM_BUCKETS-1:0] present_q;
	logic [FW-1:0]          fill_q  [NUM_BUCKETS];
	logic [31:0]            epoch_q [NUM_BUCKETS];
	logic [BW-1:0]          cbkt_q  [NUM_CURSORS];
	logic [FW-1:0]          cpos_q  [NUM_CURSORS];
	logic [31:0]            cep_q   [NUM_CURSORS];

	state_t         state_q;
	sta_pkg::cmd_t  cmd_q;
	logic [15:0]  bid_q;
	logic [31:0]  sid_q, ts_q, cut_q;
	logic [CW-1:0] cid_q;
	logic [BW-1:0] b_q;
	logic [FW-1:0] r_q, w_q;
	logic [NW-1:0] tot_q;
	logic          outv_q;
	logic [87:0]   res_q;
	logic [87:0]   out_q;

	// Memory port: one read, one write per cycle, registered read data.
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0]   wr_sess, wr_time, rd_sess_q, rd_time_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_sess[wr_addr] <= wr_sess;
			mem_time[wr_addr] <= wr_time;
		end
		if (rd_en) begin
			rd_sess_q <= mem_sess[rd_addr];
			rd_time_q <= mem_time[rd_addr];
		end
	end

	function automatic logic [AW-1:0] addr_of(logic [BW-1:0] b, logic [FW-1:0] s);
		addr_of = AW'(b * SLOTS_PER_BUCKET) + AW'(s);
	endfunction

	function automatic logic [87:0] pack(logic [1:0] st, logic [BW-1:0] b, logic [FW-1:0] s,
			logic [31:0] sid, logic [31:0] tm, logic [8:0] rem, logic ok);
		pack = {4'd0, ok, rem, tm, sid, 4'(s), 4'(b), st};
	endfunction

	wire logic [2:0]  in_cmd = s_axis_tdata[2:0];
	wire logic        bid_ok = (bid_q < 16'(NUM_BUCKETS));
	wire logic [BW-1:0] bidx = bid_q[BW-1:0];
	wire logic [BW-1:0] cb   = cbkt_q[cid_q];
	wire logic [FW-1:0] cp   = cpos_q[cid_q];
	wire logic last_b = (b_q == BW'(NUM_BUCKETS - 1));
	wire logic [NW-1:0] tot_new = tot_q + NW'(r_q - w_q);

	// The staging register parts the sequencer from the output register.
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = outv_q;
	assign m_axis_tdata  = out_q;

	// Read address and write port steering.
	always_comb begin
		rd_en = 1'b0; rd_addr = addr_of(b_q, r_q);
		wr_en = 1'b0; wr_addr = addr_of(b_q, w_q);
		wr_sess = rd_sess_q; wr_time = rd_time_q;
		unique case (state_q) inside
			S_SCAN_RD, S_AGE_RD: rd_en = 1'b1;
			S_NEXT_RD: begin
				rd_en = 1'b1; rd_addr = addr_of(cb, cp);
			end
			S_DISPATCH: if (cmd_q == sta_pkg::CMD_INSERT && bid_ok
					&& fill_q[bidx] < FW'(SLOTS_PER_BUCKET)) begin
				wr_en = 1'b1; wr_addr = addr_of(bidx, fill_q[bidx]);
				wr_sess = sid_q; wr_time = ts_q;
			end
			S_AGE_WR: wr_en = (rd_time_q >= cut_q);
			S_UPD_OUT: begin
				wr_en = (cmd_q == sta_pkg::CMD_UPDATE); wr_addr = addr_of(b_q, r_q);
				wr_sess = rd_sess_q; wr_time = ts_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			outv_q <= 1'b0;
			present_q <= '0;
			cmd_q <= sta_pkg::CMD_NONE;
			bid_q <= '0; sid_q <= '0; ts_q <= '0; cut_q <= '0; cid_q <= '0;
			b_q <= '0; r_q <= '0; w_q <= '0; tot_q <= '0;
			res_q <= '0; out_q <= '0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				fill_q[i] <= '0; epoch_q[i] <= '0;
			end
			for (int i = 0; i < NUM_CURSORS; i++) begin
				cbkt_q[i] <= '0; cpos_q[i] <= '0; cep_q[i] <= '0;
			end
		end else begin
			if (outv_q && m_axis_tready && state_q != S_DONE) outv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					cmd_q <= sta_pkg::cmd_t'(in_cmd);
					bid_q <= s_axis_tdata[18:3];
					sid_q <= s_axis_tdata[50:19];
					ts_q  <= s_axis_tdata[82:51];
					cut_q <= s_axis_tdata[114:83];
					cid_q <= CW'(s_axis_tdata[130:115] % 16'(NUM_CURSORS));
					b_q <= '0; r_q <= '0; w_q <= '0; tot_q <= '0;
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					unique case (cmd_q) inside
						sta_pkg::CMD_INSERT: begin
							state_q <= S_DONE;
							if (!bid_ok)
								res_q <= pack(sta_pkg::ST_MISS, '0, '0, '0, '0, '0, 1'b0);
							else if (fill_q[bidx] >= FW'(SLOTS_PER_BUCKET))
								res_q <= pack(sta_pkg::ST_FULL, '0, '0, '0, '0, '0, 1'b0);
							else begin
								fill_q[bidx] <= fill_q[bidx] + 1'b1;
								present_q[bidx] <= 1'b1;
								res_q <= pack(sta_pkg::ST_OK, '0, '0, '0, '0, '0, 1'b0);
							end
						end
						sta_pkg::CMD_FIND, sta_pkg::CMD_UPDATE: state_q <= S_SCAN_RD;
						sta_pkg::CMD_AGE: state_q <= S_AGE_BKT;
						sta_pkg::CMD_COPEN: begin
							state_q <= S_DONE;
							if (bid_ok && present_q[bidx]) begin
								cbkt_q[cid_q] <= bidx; cpos_q[cid_q] <= '0;
								cep_q[cid_q] <= epoch_q[bidx];
								res_q <= pack(sta_pkg::ST_OK, '0, '0, '0, '0, '0, 1'b0);
							end else
								res_q <= pack(sta_pkg::ST_MISS, '0, '0, '0, '0, '0, 1'b0);
						end
						sta_pkg::CMD_CNEXT: if (present_q[cb] && cp < fill_q[cb]
								&& cp < FW'(SLOTS_PER_BUCKET))
							state_q <= S_NEXT_RD;
						else begin
							res_q <= pack(sta_pkg::ST_MISS, '0, '0, '0, '0, '0, 1'b0);
							state_q <= S_DONE;
						end
						sta_pkg::CMD_CVALID: begin
							state_q <= S_DONE;
							if (present_q[cb] && cep_q[cid_q] == epoch_q[cb])
								res_q <= pack(sta_pkg::ST_OK, '0, '0, '0, '0, '0, 1'b1);
							else
								res_q <= pack(sta_pkg::ST_MISS, '0, '0, '0, '0, '0, 1'b0);
						end
						default: begin
							res_q <= pack(sta_pkg::ST_MISS, '0, '0, '0, '0, '0, 1'b0);
							state_q <= S_DONE;
						end
					endcase
				end
				// Scan: skip empty or exhausted buckets, else read slot r_q.
				S_SCAN_RD: begin
					if (!present_q[b_q] || r_q >= fill_q[b_q]) begin
						r_q <= '0;
						if (last_b) begin
							res_q <= pack(sta_pkg::ST_MISS, '0, '0, '0, '0, '0, 1'b0);
							state_q <= S_DONE;
						end else b_q <= b_q + 1'b1;
					end else state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (rd_sess_q == sid_q) state_q <= S_UPD_OUT;
					else begin
						r_q <= r_q + 1'b1; state_q <= S_SCAN_RD;
					end
				end
				S_UPD_OUT: begin
					res_q <= pack(sta_pkg::ST_OK, b_q, r_q, rd_sess_q,
						(cmd_q == sta_pkg::CMD_UPDATE) ? ts_q : rd_time_q, '0, 1'b0);
					state_q <= S_DONE;
				end
				S_AGE_BKT: begin
					r_q <= '0; w_q <= '0;
					if (present_q[b_q] && fill_q[b_q] != '0) state_q <= S_AGE_RD;
					else if (last_b) begin
						res_q <= pack(sta_pkg::ST_OK, '0, '0, '0, '0,
							(tot_q > NW'(511)) ? 9'd511 : 9'(tot_q), 1'b0);
						state_q <= S_DONE;
					end else b_q <= b_q + 1'b1;
				end
				S_AGE_RD: state_q <= S_AGE_WR;
				S_AGE_WR: begin
					if (rd_time_q >= cut_q) w_q <= w_q + 1'b1;
					r_q <= r_q + 1'b1;
					state_q <= (r_q + 1'b1 >= fill_q[b_q]) ? S_AGE_END : S_AGE_RD;
				end
				S_AGE_END: begin
					if (w_q != r_q) begin
						fill_q[b_q] <= w_q;
						epoch_q[b_q] <= epoch_q[b_q] + 32'd1;
						tot_q <= tot_new;
					end
					if (last_b) begin
						res_q <= pack(sta_pkg::ST_OK, '0, '0, '0, '0,
							(tot_new > NW'(511)) ? 9'd511 : 9'(tot_new), 1'b0);
						state_q <= S_DONE;
					end else begin
						b_q <= b_q + 1'b1; state_q <= S_AGE_BKT;
					end
				end
				S_NEXT_RD: state_q <= S_NEXT_OUT;
				S_NEXT_OUT: begin
					res_q <= pack(sta_pkg::ST_OK, cb, cp, rd_sess_q, rd_time_q, '0, 1'b0);
					cpos_q[cid_q] <= cp + 1'b1;
					state_q <= S_DONE;
				end
				// Move the staged result out once the output register is free.
				S_DONE: if (!outv_q || m_axis_tready) begin
					out_q <= res_q;
					outv_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/sta_checker.sv -----
// Port-level checker for the session table core, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module sta_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [87:0]  m_axis_tdata
);
	// A held result must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	// One word at a time: no accept right after an accept.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");
	// Status never shows the unused code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] <= sta_pkg::ST_FULL)
		else $error("bad status");
	// cursor_ok set only with status ok.
	a_cok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[83] |-> m_axis_tdata[1:0] == sta_pkg::ST_OK)
		else $error("cursor_ok with failing status");
endmodule

bind session_table_with_aging_core sta_checker u_sta_checker (.*);
`default_nettype wire
